/* sv/dsa_pkg.sv */
// Shared types, register codes and angle constants for the slope/aspect block.
// No dependencies.
package dsa_pkg;

   typedef struct packed {
      logic signed [31:0] elevation;
      logic               elevation_valid;
      logic               start_of_frame;
   } req_type;

   typedef struct packed {
      logic [14:0] slope_deg;
      logic        slope_valid;
      logic [16:0] aspect_deg;
      logic        aspect_valid;
      logic [11:0] center_column;
      logic [15:0] center_row;
   } rsp_type;

   localparam logic [1:0] REG_IMAGE_COLUMNS = 2'd0;
   localparam logic [1:0] REG_INV_GRID_X    = 2'd1;
   localparam logic [1:0] REG_INV_GRID_Y    = 2'd2;

   localparam logic [12:0] IMAGE_COLUMNS_RESET = 13'd4096;
   localparam logic [31:0] INV_GRID_RESET      = 32'd16777216;

   // degrees in Q.16
   localparam logic signed [31:0] DEG90_Q16  = 32'sd5898240;
   localparam logic signed [31:0] DEG180_Q16 = 32'sd11796480;
   localparam logic signed [31:0] DEG360_Q16 = 32'sd23592960;
   localparam logic signed [31:0] DEG450_Q16 = 32'sd29491200;

   localparam logic [14:0] SLOPE_MAX_Q8  = 15'd23040;
   localparam logic [16:0] ASPECT_WRAP_Q8 = 17'd92160;

   // 2.0 in the Q26 scale of the gradient terms
   localparam logic signed [63:0] TWO_Q26 = 64'sd134217728;

   localparam int ANGLE_TABLE_LEN = 32;

   localparam logic signed [31:0] ANGLE_STEP_Q16 [ANGLE_TABLE_LEN] = '{
      32'sd2949120, 32'sd1740967, 32'sd919879, 32'sd466945,
      32'sd234379,  32'sd117304,  32'sd58666,  32'sd29335,
      32'sd14668,   32'sd7334,    32'sd3667,   32'sd1833,
      32'sd917,     32'sd458,     32'sd229,    32'sd115,
      32'sd57,      32'sd29,      32'sd14,     32'sd7,
      32'sd4,       32'sd2,       32'sd1,      32'sd0,
      32'sd0,       32'sd0,       32'sd0,      32'sd0,
      32'sd0,       32'sd0,       32'sd0,      32'sd0
   };

   // x of a vectoring pass started at (2.0, 0): the CORDIC gain on 2.0
   function automatic logic signed [63:0] cordic_gain_two(input int steps);
      logic signed [63:0] x;
      logic signed [63:0] y;
      logic signed [63:0] xs;
      logic signed [63:0] ys;
      x = TWO_Q26;
      y = 64'sd0;
      for (int i = 0; i < ANGLE_TABLE_LEN; i++) begin
         if (i < steps) begin
            xs = x >>> i;
            ys = y >>> i;
            if (!y[63]) begin
               x = x + ys;
               y = y - xs;
            end else begin
               x = x - ys;
               y = y + xs;
            end
         end
      end
      return x;
   endfunction

endpackage

/* sv/dsa_cordic.sv */
// Iterative CORDIC vectoring unit, one micro-rotation per cycle, angle in Q.16 degrees.
// Depends on dsa_pkg (angle table).
module dsa_cordic #(
   parameter int STEPS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [63:0] x0,
   input  logic signed [63:0] y0,
   output logic signed [63:0] x_out,
   output logic signed [31:0] z_out,
   output logic               done
);
   import dsa_pkg::*;

   localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;

   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic signed [63:0] x_ff, x_in, y_ff, y_in;
   logic signed [31:0] z_ff, z_in;
   logic signed [63:0] xs, ys;
   logic signed [31:0] ang;
   logic               last;

   always_comb begin
      xs     = x_ff >>> cnt_ff;
      ys     = y_ff >>> cnt_ff;
      ang    = ANGLE_STEP_Q16[5'(cnt_ff)];
      last   = (cnt_ff == CNT_W'(STEPS - 1));
      x_in   = x_ff;
      y_in   = y_ff;
      z_in   = z_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = busy_ff && last;
      if (start) begin
         x_in    = x0;
         y_in    = y0;
         z_in    = 32'sd0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!y_ff[63]) begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + ang;
         end else begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - ang;
         end
         cnt_in = cnt_ff + 1'b1;
         if (last) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
   end

   assign x_out = x_ff;
   assign z_out = z_ff;
   assign done  = done_ff;

endmodule

/* sv/dem_slope_aspect_3x3.sv */
// Slope and azimuth aspect of a streamed elevation raster over a 4-neighbour cross.
// Depends on dsa_pkg and dsa_cordic.
// Sequence per word: store read, then window; a border word gives no result and an invalid
//   cross goes straight to the output step; a flat cross adds the two multiplies and two passes
//   (hypot, then atan) through the one CORDIC unit, and a full cross a third, aspect pass.
// Throughput: one word at a time; the next word is taken the cycle after the result is loaded,
//   or after the window step for a word with no result; a held output reg stalls the input.
// Reset: synchronous; clears counters, window and handshake; line stores are not cleared.
module dem_slope_aspect_3x3 #(
   parameter int MAX_COLUMNS  = 4096,
   parameter int CORDIC_STEPS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  dsa_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output dsa_pkg::rsp_type rsp_data,
   input  logic             csr_psel,
   input  logic             csr_penable,
   input  logic             csr_pwrite,
   input  logic [3:0]       csr_paddr,
   input  logic [31:0]      csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   import dsa_pkg::*;

   localparam int CW    = $clog2(MAX_COLUMNS);
   localparam int CLW0  = $clog2(MAX_COLUMNS + 1);
   localparam int CLW   = (CLW0 > 13) ? CLW0 : 13;
   localparam logic signed [63:0] K2 = cordic_gain_two(CORDIC_STEPS);

   // one-hot sequencer
   typedef enum logic [11:0] {
      ST_IDLE = 12'b000000000001,  // waiting for a word
      ST_RD   = 12'b000000000010,  // line store read
      ST_WIN  = 12'b000000000100,  // window shift, store write-back, differences
      ST_MX   = 12'b000000001000,  // |dx| * inv_grid_x
      ST_MY   = 12'b000000010000,  // |dy| * inv_grid_y
      ST_P1   = 12'b000000100000,  // start hypot pass
      ST_W1   = 12'b000001000000,
      ST_P3   = 12'b000010000000,  // start atan(hypot/2) pass
      ST_W3   = 12'b000100000000,
      ST_PA   = 12'b001000000000,  // start aspect pass
      ST_WA   = 12'b010000000000,
      ST_FIN  = 12'b100000000000   // round, fold, hand to output reg
   } state_type;

   state_type state_ff, state_in;

   // configuration
   logic [12:0] img_cols_ff;
   logic [31:0] inv_gx_ff, inv_gy_ff;
   logic        csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         img_cols_ff <= IMAGE_COLUMNS_RESET;
         inv_gx_ff   <= INV_GRID_RESET;
         inv_gy_ff   <= INV_GRID_RESET;
      end else if (csr_wr) begin
         unique case (csr_paddr[3:2])
            REG_IMAGE_COLUMNS: img_cols_ff <= csr_pwdata[12:0];
            REG_INV_GRID_X:    inv_gx_ff   <= csr_pwdata;
            REG_INV_GRID_Y:    inv_gy_ff   <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         REG_IMAGE_COLUMNS: csr_prdata = {19'd0, img_cols_ff};
         REG_INV_GRID_X:    csr_prdata = inv_gx_ff;
         REG_INV_GRID_Y:    csr_prdata = inv_gy_ff;
         default:           csr_prdata = 32'd0;
      endcase
   end

   // raster position; the row width is clamped to 3..MAX_COLUMNS
   logic [CW-1:0]  col_cnt_ff, col_ff;
   logic [15:0]    row_cnt_ff, row_ff;
   logic [CLW-1:0] cols_eff, col_nx1;
   logic [CW-1:0]  col_base, col_now, col_next;
   logic [15:0]    row_base, row_now, row_next;
   logic           accept;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      cols_eff = CLW'(img_cols_ff);
      if (cols_eff < CLW'(3)) begin
         cols_eff = CLW'(3);
      end else if (cols_eff > CLW'(MAX_COLUMNS)) begin
         cols_eff = CLW'(MAX_COLUMNS);
      end
      col_base = req_data.start_of_frame ? '0 : col_cnt_ff;
      row_base = req_data.start_of_frame ? 16'd0 : row_cnt_ff;
      col_now  = col_base;
      row_now  = row_base;
      // row width lowered mid-row: this word opens a new row
      if (CLW'(col_base) >= cols_eff) begin
         col_now = '0;
         row_now = row_base + 16'd1;
      end
      col_nx1 = CLW'(col_now) + CLW'(1);
      if (col_nx1 >= cols_eff) begin
         col_next = '0;
         row_next = row_now + 16'd1;
      end else begin
         col_next = CW'(col_nx1);
         row_next = row_now;
      end
   end

   logic [32:0] sample_ff, prev_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_cnt_ff <= '0;
         row_cnt_ff <= 16'd0;
      end else if (accept) begin
         col_cnt_ff <= col_next;
         row_cnt_ff <= row_next;
      end
      if (accept) begin
         col_ff    <= col_now;
         row_ff    <= row_now;
         sample_ff <= {req_data.elevation_valid, req_data.elevation};
      end
   end

   // line stores: middle holds the previous row, upper the one before it
   logic [32:0]   mid_mem [MAX_COLUMNS];
   logic [32:0]   upr_mem [MAX_COLUMNS];
   logic [32:0]   mid_rd_ff, upr_rd_ff;
   logic [32:0]   win_ff [3];
   logic [CW-1:0] col_m1;

   assign col_m1 = col_ff - CW'(1);

   always_ff @(posedge clock) begin
      mid_rd_ff <= mid_mem[col_ff];
      upr_rd_ff <= upr_mem[col_m1];
      if (state_ff == ST_WIN) begin
         mid_mem[col_ff] <= sample_ff;
         if (col_ff != '0) begin
            upr_mem[col_m1] <= win_ff[2];
         end
      end
   end

   // the bottom sample is always the word taken just before this one
   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff[0] <= '0;
         win_ff[1] <= '0;
         win_ff[2] <= '0;
      end else if (state_ff == ST_WIN) begin
         win_ff[0] <= win_ff[1];
         win_ff[1] <= win_ff[2];
         win_ff[2] <= mid_rd_ff;
      end
      if (state_ff == ST_WIN) begin
         prev_ff <= sample_ff;
      end
   end

   // cross differences
   logic [32:0]        s_left, s_centre, s_right, s_top, s_bottom;
   logic signed [32:0] ax, ay, ax_neg, ay_neg;
   logic signed [63:0] axw, ayw;
   logic               emit, ok, aok;

   always_comb begin
      s_left   = win_ff[1];
      s_centre = win_ff[2];
      s_right  = mid_rd_ff;
      s_top    = upr_rd_ff;
      s_bottom = prev_ff;
      ax     = 33'(signed'(s_left[31:0])) - 33'(signed'(s_right[31:0]));
      ay     = 33'(signed'(s_bottom[31:0])) - 33'(signed'(s_top[31:0]));
      ax_neg = -ax;
      ay_neg = -ay;
      axw    = 64'(ax) <<< 16;
      ayw    = 64'(ay) <<< 16;
      emit   = (col_ff != '0) && (row_ff != 16'd0);
      ok     = emit && (col_ff >= CW'(2)) && (row_ff >= 16'd2) &&
               s_left[32] && s_centre[32] && s_right[32] && s_top[32] && s_bottom[32];
      aok    = ok && ((ax != 33'sd0) || (ay != 33'sd0));
   end

   logic [31:0]        dxa_ff, dya_ff;
   logic               ok_ff, aok_ff, asp_neg_ff, asp_bpos_ff;
   logic signed [63:0] asp_x_ff, asp_y_ff;

   always_ff @(posedge clock) begin
      if (state_ff == ST_WIN) begin
         dxa_ff      <= ax[32] ? ax_neg[31:0] : ax[31:0];
         dya_ff      <= ay[32] ? ay_neg[31:0] : ay[31:0];
         ok_ff       <= ok;
         aok_ff      <= aok;
         asp_neg_ff  <= ax[32];
         asp_bpos_ff <= !ay[32];
         asp_x_ff    <= ax[32] ? -axw : axw;
         asp_y_ff    <= ax[32] ? -ayw : ayw;
      end
   end

   // one multiplier, shared by both axes
   logic [63:0]        prod_ff;
   logic [31:0]        mul_a, mul_b;
   logic signed [63:0] gx_ff;

   assign mul_a = (state_ff == ST_MX) ? dxa_ff : dya_ff;
   assign mul_b = (state_ff == ST_MX) ? inv_gx_ff : inv_gy_ff;

   always_ff @(posedge clock) begin
      if (state_ff == ST_MX || state_ff == ST_MY) begin
         prod_ff <= 64'(mul_a) * 64'(mul_b);
      end
      if (state_ff == ST_MY) begin
         gx_ff <= signed'(prod_ff >> 6);
      end
   end

   // shared CORDIC
   logic               cor_start, cor_done;
   logic signed [63:0] cor_x0, cor_y0, cor_x;
   logic signed [31:0] cor_z;
   logic signed [63:0] hyp_ff;
   logic signed [31:0] slope_z_ff, asp_z_ff;

   always_comb begin
      cor_start = (state_ff == ST_P1) || (state_ff == ST_P3) || (state_ff == ST_PA);
      cor_x0    = asp_x_ff;
      cor_y0    = asp_y_ff;
      if (state_ff == ST_P1) begin
         cor_x0 = gx_ff;
         cor_y0 = signed'(prod_ff >> 6);
      end else if (state_ff == ST_P3) begin
         cor_x0 = K2;
         cor_y0 = hyp_ff;
      end
   end

   dsa_cordic #(
      .STEPS (CORDIC_STEPS)
   ) u_cordic (
      .clock (clock),
      .reset (reset),
      .start (cor_start),
      .x0    (cor_x0),
      .y0    (cor_y0),
      .x_out (cor_x),
      .z_out (cor_z),
      .done  (cor_done)
   );

   always_ff @(posedge clock) begin
      if (state_ff == ST_W1 && cor_done) begin
         hyp_ff <= cor_x;
      end
      if (state_ff == ST_W3 && cor_done) begin
         slope_z_ff <= cor_z;
      end
      if (state_ff == ST_WA && cor_done) begin
         asp_z_ff <= cor_z;
      end
   end

   // rounding, clamp and azimuth fold
   logic signed [31:0] sr, aa, ar;
   logic [14:0]        slope_q8;
   logic [16:0]        aspect_q8;

   always_comb begin
      sr = (slope_z_ff + 32'sd128) >>> 8;
      if (sr < 32'sd0) begin
         sr = 32'sd0;
      end else if (sr > 32'(SLOPE_MAX_Q8)) begin
         sr = 32'(SLOPE_MAX_Q8);
      end
      slope_q8 = ok_ff ? sr[14:0] : 15'd0;

      aa = asp_z_ff;
      if (asp_neg_ff) begin
         aa = (asp_bpos_ff ? DEG180_Q16 : -DEG180_Q16) + asp_z_ff;
      end
      if (aa > DEG90_Q16) begin
         aa = DEG450_Q16 - aa;
      end else begin
         aa = DEG90_Q16 - aa;
      end
      if (aa >= DEG360_Q16) begin
         aa = aa - DEG360_Q16;
      end
      if (aa < 32'sd0) begin
         aa = 32'sd0;
      end
      ar = (aa + 32'sd128) >>> 8;
      if (ar >= 32'(ASPECT_WRAP_Q8)) begin
         ar = ar - 32'(ASPECT_WRAP_Q8);
      end
      aspect_q8 = aok_ff ? ar[16:0] : 17'd0;
   end

   // output register
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;
   logic    out_load;

   assign out_load = (state_ff == ST_FIN) && (!rsp_valid_ff || !rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (out_load) begin
         rsp_data_ff.slope_deg     <= slope_q8;
         rsp_data_ff.slope_valid   <= ok_ff;
         rsp_data_ff.aspect_deg    <= aspect_q8;
         rsp_data_ff.aspect_valid  <= aok_ff;
         rsp_data_ff.center_column <= 12'(col_m1);
         rsp_data_ff.center_row    <= row_ff - 16'd1;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (accept) state_in = ST_RD;
         ST_RD:   state_in = ST_WIN;
         ST_WIN: begin
            if (!emit) begin
               state_in = ST_IDLE;
            end else if (!ok) begin
               state_in = ST_FIN;
            end else begin
               state_in = ST_MX;
            end
         end
         ST_MX:   state_in = ST_MY;
         ST_MY:   state_in = ST_P1;
         ST_P1:   state_in = ST_W1;
         ST_W1:   if (cor_done) state_in = ST_P3;
         ST_P3:   state_in = ST_W3;
         ST_W3: begin
            if (cor_done) begin
               state_in = aok_ff ? ST_PA : ST_FIN;
            end
         end
         ST_PA:   state_in = ST_WA;
         ST_WA:   if (cor_done) state_in = ST_FIN;
         ST_FIN:  if (out_load) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // checks
   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      cor_done |-> (state_ff == ST_W1 || state_ff == ST_W3 || state_ff == ST_WA))
      else $error("cordic finished outside a wait state");

   a_slope_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.slope_deg <= SLOPE_MAX_Q8))
      else $error("slope out of range");

   a_aspect_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.aspect_deg < ASPECT_WRAP_Q8))
      else $error("aspect out of range");

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff.slope_valid) |->
         (rsp_data_ff.slope_deg == 15'd0 && !rsp_data_ff.aspect_valid))
      else $error("invalid cross gave a value");

   a_one_load: assert property (@(posedge clock) disable iff (reset)
      out_load |=> (state_ff == ST_IDLE && rsp_valid_ff))
      else $error("result load did not retire the word");

endmodule

/* sim/dsa_checker.sv */
// Checker for dem_slope_aspect_3x3: tracks register writes, predicts each result word
// from the accepted input words and compares it with what the block returns.
// Depends on dsa_pkg.
module dsa_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  dsa_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  dsa_pkg::rsp_type rsp_data,
   input  logic             csr_psel,
   input  logic             csr_penable,
   input  logic             csr_pwrite,
   input  logic [3:0]       csr_paddr,
   input  logic [31:0]      csr_pwdata,
   input  logic             csr_pready,
   output int               fail_count,
   output int               pending,
   output int               words_in,
   output int               results_seen
);
   timeunit 1ns;
   timeprecision 1ps;
   import dsa_pkg::*;

   localparam int LINE_LEN = 4096;
   localparam int STEPS    = 16;

   logic [32:0] upper_row [LINE_LEN];
   logic [32:0] middle_row [LINE_LEN];
   logic [32:0] cross_win [3];
   int          col_cnt;
   logic [15:0] row_cnt;
   logic [12:0] cfg_cols;
   logic [31:0] cfg_gx;
   logic [31:0] cfg_gy;
   rsp_type     expected_q [$];

   function automatic void vector_pass(inout longint x, inout longint y, inout longint z);
      longint xs;
      longint ys;
      for (int i = 0; i < STEPS; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y >= 0) begin
            x = x + ys; y = y - xs; z = z + ANGLE_STEP_Q16[i];
         end else begin
            x = x - ys; y = y + xs; z = z - ANGLE_STEP_Q16[i];
         end
      end
   endfunction

   function automatic logic [14:0] slope_of(longint l, longint r, longint t, longint b);
      logic [63:0] adx;
      logic [63:0] ady;
      longint x, y, z, k2, ky, kz, res;
      adx = (l >= r) ? l - r : r - l;
      ady = (b >= t) ? b - t : t - b;
      x = longint'((adx * {32'd0, cfg_gx}) >> 6);
      y = longint'((ady * {32'd0, cfg_gy}) >> 6);
      z = 0; k2 = 64'sd1 << 27; ky = 0; kz = 0;
      vector_pass(x, y, z);
      vector_pass(k2, ky, kz);
      y = x; x = k2; z = 0;
      vector_pass(x, y, z);
      res = (z + 128) >>> 8;
      if (res < 0) res = 0;
      if (res > 23040) res = 23040;
      return res[14:0];
   endfunction

   function automatic logic [16:0] azimuth_of(longint ax, longint ay);
      longint x, y, z, base, a, res;
      x = ax * 65536; y = ay * 65536; z = 0; base = 0;
      if (x < 0) begin
         base = (ay >= 0) ? longint'(DEG180_Q16) : -longint'(DEG180_Q16);
         x = -x; y = -y;
      end
      vector_pass(x, y, z);
      a = base + z;
      if (a > DEG90_Q16) a = longint'(DEG450_Q16) - a;
      else a = longint'(DEG90_Q16) - a;
      if (a >= DEG360_Q16) a = a - DEG360_Q16;
      if (a < 0) a = 0;
      res = (a + 128) >>> 8;
      if (res >= 92160) res = res - 92160;
      return res[16:0];
   endfunction

   task automatic predict_word(input req_type w);
      int          cols;
      int          c;
      logic [32:0] s, top, bot, lf, ce, rt;
      rsp_type     e;
      longint      l, r, t, b;
      cols = cfg_cols;
      if (cols < 3) cols = 3;
      if (cols > LINE_LEN) cols = LINE_LEN;
      if (w.start_of_frame) begin
         col_cnt = 0; row_cnt = '0;
      end
      // register lowered mid-row: wrap to a new row
      if (col_cnt >= cols) begin
         col_cnt = 0; row_cnt = row_cnt + 16'd1;
      end
      c = col_cnt;
      s = {w.elevation_valid, w.elevation};
      cross_win[0] = cross_win[1];
      cross_win[1] = cross_win[2];
      cross_win[2] = middle_row[c];
      lf = cross_win[0]; ce = cross_win[1]; rt = cross_win[2];
      top = '0; bot = '0;
      if (c >= 1) begin
         top = upper_row[c-1];
         bot = middle_row[c-1];
         upper_row[c-1] = ce;
      end
      middle_row[c] = s;
      if (c >= 1 && row_cnt >= 1) begin
         e = '0;
         if (c >= 2 && row_cnt >= 2 && top[32] && lf[32] && ce[32] && rt[32] && bot[32]) begin
            l = longint'(signed'(lf[31:0])); r = longint'(signed'(rt[31:0]));
            t = longint'(signed'(top[31:0])); b = longint'(signed'(bot[31:0]));
            e.slope_deg = slope_of(l, r, t, b);
            e.slope_valid = 1'b1;
            // flat cross leaves the aspect invalid
            if (l != r || t != b) begin
               e.aspect_deg = azimuth_of(l - r, b - t);
               e.aspect_valid = 1'b1;
            end
         end
         e.center_column = 12'(c - 1);
         e.center_row = row_cnt - 16'd1;
         expected_q.push_back(e);
      end
      col_cnt = c + 1;
      if (col_cnt >= cols) begin
         col_cnt = 0; row_cnt = row_cnt + 16'd1;
      end
      words_in++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LINE_LEN; i++) begin
            upper_row[i] = '0; middle_row[i] = '0;
         end
         for (int i = 0; i < 3; i++) cross_win[i] = '0;
         col_cnt = 0; row_cnt = '0;
         cfg_cols = IMAGE_COLUMNS_RESET;
         cfg_gx = INV_GRID_RESET;
         cfg_gy = INV_GRID_RESET;
         expected_q.delete();
         fail_count = 0; words_in = 0; results_seen = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[3:2])
               REG_IMAGE_COLUMNS: cfg_cols = csr_pwdata[12:0];
               REG_INV_GRID_X:    cfg_gx = csr_pwdata;
               REG_INV_GRID_Y:    cfg_gy = csr_pwdata;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) predict_word(req_data);
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (expected_q.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected result word %p", $time, rsp_data);
            end else begin
               if (rsp_data !== expected_q[0]) begin
                  fail_count++;
                  $display("%0t: mismatch expected %p actual %p", $time,
                           expected_q[0], rsp_data);
               end
               void'(expected_q.pop_front());
            end
         end
      end
      pending = expected_q.size();
   end

endmodule

/* sim/tb_top.sv */
// Top of the slope/aspect testbench: clock, reset, register writes, raster stimulus
// with idling and back-pressure, watchdog and verdict. Depends on dsa_pkg, dsa_checker
// and dem_slope_aspect_3x3.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import dsa_pkg::*;

   // cycles with no word moving on any port before the run is declared hung
   localparam int QUIET_LIMIT = 3000;
   localparam int HOLD_CYCLES = 300;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int fail_count, pending, words_in, results_seen;
   int send_idle_pct = 0;
   int stall_pct = 0;
   int quiet_cycles = 0;
   int hold_left = 0;
   logic hold_go = 1'b0;
   logic hold_done = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   dem_slope_aspect_3x3 dut (.*);

   dsa_checker chk (.*);

   // Receiver: random stall, plus one long hold-off so the block backs up its input.
   always @(posedge clock) begin
      if (hold_go && !hold_done) begin
         hold_done <= 1'b1;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   // Watchdog: count cycles where nothing moves.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_psel) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: watchdog expired, %0d results outstanding", $time, pending);
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   // APB write: setup then access; the register lands at the access edge.
   task automatic csr_write(input logic [1:0] idx, input logic [31:0] value);
      @(posedge clock);
      csr_psel <= 1'b1; csr_pwrite <= 1'b1; csr_penable <= 1'b0;
      csr_paddr <= {idx, 2'b00}; csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
   endtask

   // One word on the input channel, with random idle cycles ahead of it.
   task automatic send_word(input req_type w);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Drain: all results back, then an idle wait for words that give no result.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_elev();
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return 32'd0;                       // flats come out of repeated zeros
         2: return $urandom_range(0, 2);
         default: return 32'($urandom_range(0, 511)) - 32'd256;
      endcase
   endfunction

   task automatic run_frame(input int width, input int rows, input bit with_sof);
      req_type w;
      for (int r = 0; r < rows; r++) begin
         for (int c = 0; c < width; c++) begin
            w.start_of_frame = with_sof && r == 0 && c == 0;
            w.elevation_valid = ($urandom_range(0, 19) != 0);
            w.elevation = pick_elev();
            send_word(w);
         end
      end
   endtask

   // Directed 3-wide frame: extreme values, a cross with equal left and right, an invalid sample.
   task automatic directed_frame();
      logic [31:0] vals [15] = '{
         32'd0, 32'h7FFF_FFFF, 32'd0,
         32'h8000_0000, 32'd5, 32'h7FFF_FFFF,
         32'd0, 32'h8000_0000, 32'd0,
         32'd7, 32'd7, 32'd7,
         32'd1, 32'hFFFF_FFFF, 32'd2 };
      req_type w;
      for (int i = 0; i < 15; i++) begin
         w.start_of_frame = (i == 0);
         w.elevation_valid = (i != 13);
         w.elevation = vals[i];
         send_word(w);
      end
   endtask

   initial begin
      int cols_list [8] = '{0, 5, 4, 9, 3, 7, 12, 6};
      logic [31:0] gx, gy;
      int width, sent;
      reset <= 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part at reset spacing
      csr_write(REG_IMAGE_COLUMNS, 32'd3);
      directed_frame();
      settle();

      // over-range register value clamps to the store length; a short partial first row
      csr_write(REG_IMAGE_COLUMNS, 32'd8191);
      csr_write(REG_INV_GRID_X, 32'hFFFF_FFFF);
      csr_write(REG_INV_GRID_Y, 32'd1);
      run_frame(12, 1, 1);
      run_frame(10, 1, 0);
      settle();

      for (int p = 0; p < 8; p++) begin
         case (p % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 68; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 68; end
            default: begin send_idle_pct = 31; stall_pct = 31; end
         endcase
         case (p)
            0: begin gx = 32'd1 << 24; gy = 32'd1 << 24; end
            1: begin gx = 32'hFFFF_FFFF; gy = 32'hFFFF_FFFF; end
            2: begin gx = 32'd0; gy = $urandom; end         // zero inverse spacing on x
            3: begin gx = 32'd1; gy = 32'd0; end
            default: begin gx = $urandom; gy = $urandom_range(1, 32'h0400_0000); end
         endcase
         csr_write(REG_IMAGE_COLUMNS, cols_list[p]);
         csr_write(REG_INV_GRID_X, gx);
         csr_write(REG_INV_GRID_Y, gy);
         width = (cols_list[p] < 3) ? 3 : cols_list[p];
         if (p == 2) hold_go <= 1'b1;
         if (p == 6) begin
            // shrink the line mid-row: the next word wraps to a fresh row
            run_frame(width, 2, 1);
            run_frame(7, 1, 0);
            settle();
            csr_write(REG_IMAGE_COLUMNS, 32'd4);
            run_frame(4, 8, 0);
         end else begin
            sent = 0;
            while (sent < 30) begin
               run_frame(width, $urandom_range(3, 6), 1);
               sent += width * 4;
            end
         end
         settle();
      end

      repeat (20) @(posedge clock);
      $display("covered %0d input words, %0d result words, widths 3..12 plus a clamped",
               words_in, results_seen);
      $display("over-range width, a mid-row shrink, one long hold-off and four idle mixes");
      if (fail_count == 0 && pending == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
